// ===== hdl/mrwt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrwt_pkg
// Shared constants and command/status types for the witness test.
// ----------------------------------------------------------------------------
package mrwt_pkg;
   localparam int DEFAULT_WIDTH = 64;

   typedef struct packed {
      logic load;
      logic mod_start;
      logic mul_start;
      logic mul_sel_rb;
      logic mul_sel_sq;
      logic shift_d;
      logic strip_d;
      logic sq_y;
   } cmd_type;

   typedef struct packed {
      logic n_small;
      logic n_even;
      logic n_two;
      logic d_even;
      logic e_zero;
      logic e_odd;
      logic mod_done;
      logic mul_done;
      logic y_one;
      logic y_nm1;
      logic t_nm1;
      logic t_odd;
   } status_type;
endpackage

// ===== hdl/mrwt_mulmod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrwt_mulmod
// Serial modular multiplier: one bit of the multiplier per cycle, top first.
// ----------------------------------------------------------------------------
module mrwt_mulmod
   import mrwt_pkg::*;
#(
   parameter int WIDTH = DEFAULT_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] op_a,
   input  logic [WIDTH-1:0] op_c,
   input  logic [WIDTH-1:0] modulus,
   output logic             done,
   output logic [WIDTH-1:0] product
);
   localparam int CW = $clog2(WIDTH + 1);
   logic [WIDTH-1:0] acc_ff, acc_in, a_ff, c_ff, m_ff, dbl;
   logic [CW-1:0]    cnt_ff;
   logic             run_ff, done_ff;

   function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
         input logic [WIDTH-1:0] y, input logic [WIDTH-1:0] m);
      logic [WIDTH-1:0] room;
      room = m - y;
      return (x >= room) ? (x - room) : (x + y);
   endfunction

   always_comb begin
      dbl    = add_mod(acc_ff, acc_ff, m_ff);
      acc_in = c_ff[WIDTH-1] ? add_mod(dbl, a_ff, m_ff) : dbl;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CW'(WIDTH);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         acc_ff <= '0;
         a_ff   <= op_a;
         c_ff   <= op_c;
         m_ff   <= modulus;
      end else if (run_ff) begin
         acc_ff <= acc_in;
         c_ff   <= {c_ff[WIDTH-2:0], 1'b0};
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule

// ===== hdl/mrwt_modred.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrwt_modred
// Restoring reduction x mod m, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mrwt_modred
   import mrwt_pkg::*;
#(
   parameter int WIDTH = DEFAULT_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] modulus,
   output logic             done,
   output logic [WIDTH-1:0] remainder
);
   localparam int CW = $clog2(WIDTH + 1);
   logic [WIDTH:0]   rem_ff, trial;
   logic [WIDTH-1:0] x_ff, m_ff;
   logic [CW-1:0]    cnt_ff;
   logic             run_ff, done_ff;

   always_comb trial = {rem_ff[WIDTH-1:0], x_ff[WIDTH-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CW'(WIDTH);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         rem_ff <= '0;
         x_ff   <= dividend;
         m_ff   <= modulus;
      end else if (run_ff) begin
         rem_ff <= (trial >= {1'b0, m_ff}) ? trial - {1'b0, m_ff} : trial;
         x_ff   <= {x_ff[WIDTH-2:0], 1'b0};
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff[WIDTH-1:0];
endmodule

// ===== hdl/mrwt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrwt_datapath
// Operand registers, exponent, shared multiplier and reduction unit.
// ----------------------------------------------------------------------------
module mrwt_datapath
   import mrwt_pkg::*;
#(
   parameter int WIDTH = DEFAULT_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [WIDTH-1:0] candidate,
   input  logic [WIDTH-1:0] witness_base,
   input  cmd_type          cmd,
   output status_type       status
);
   logic [WIDTH-1:0] n_ff, nm1_ff, b_ff, e_ff, r_ff, t_ff, y_ff;
   logic [WIDTH-1:0] ma, mc, prod, rem;
   logic             mul_done, mod_done;

   always_comb begin
      ma = cmd.mul_sel_sq ? y_ff : (cmd.mul_sel_rb ? r_ff : b_ff);
      mc = cmd.mul_sel_sq ? y_ff : b_ff;
   end

   mrwt_mulmod #(.WIDTH(WIDTH)) u_mul (
      .clock(clock), .reset(reset), .start(cmd.mul_start), .op_a(ma), .op_c(mc),
      .modulus(n_ff), .done(mul_done), .product(prod)
   );

   mrwt_modred #(.WIDTH(WIDTH)) u_mod (
      .clock(clock), .reset(reset), .start(cmd.mod_start), .dividend(b_ff),
      .modulus(n_ff), .done(mod_done), .remainder(rem)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff   <= candidate;
         nm1_ff <= candidate - WIDTH'(1);
         e_ff   <= candidate - WIDTH'(1);
         b_ff   <= witness_base;
         r_ff   <= WIDTH'(1);
      end
      if (cmd.strip_d) e_ff <= {1'b0, e_ff[WIDTH-1:1]};
      if (mod_done) begin
         b_ff <= rem;
         t_ff <= e_ff;
      end
      if (mul_done) begin
         if (cmd.mul_sel_sq) y_ff <= prod;
         else if (cmd.mul_sel_rb) r_ff <= prod;
         else b_ff <= prod;
      end
      if (cmd.shift_d) begin
         e_ff <= {1'b0, e_ff[WIDTH-1:1]};
         if (e_ff == WIDTH'(1)) y_ff <= r_ff;
      end
      if (cmd.sq_y) t_ff <= {t_ff[WIDTH-2:0], 1'b0};
   end

   always_comb begin
      status          = '0;
      status.n_small  = n_ff < WIDTH'(2);
      status.n_even   = ~n_ff[0];
      status.n_two    = n_ff == WIDTH'(2);
      status.d_even   = ~e_ff[0];
      status.e_zero   = e_ff == '0;
      status.e_odd    = e_ff[0];
      status.mod_done = mod_done;
      status.mul_done = mul_done;
      status.y_one    = y_ff == WIDTH'(1);
      status.y_nm1    = y_ff == nm1_ff;
      status.t_nm1    = t_ff == nm1_ff;
      status.t_odd    = t_ff[0];
   end
endmodule

// ===== hdl/mrwt_control.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrwt_control
// Sequencer: screening, odd-part strip, exponentiation, squaring loop.
// ----------------------------------------------------------------------------
module mrwt_control
   import mrwt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   output logic       rsp_valid,
   output logic       rsp_probable_prime,
   input  status_type status,
   output cmd_type    cmd
);
   typedef enum logic [3:0] {
      S_IDLE, S_SCREEN, S_STRIP, S_MOD, S_EXP, S_MUL_R, S_BSQ, S_MUL_B, S_ADV,
      S_CHECK, S_SQ
   } state_type;

   state_type state_ff;
   logic      busy_ff, valid_ff, pp_ff;

   always_comb begin
      cmd = '0;
      cmd.load = start && !busy_ff;
      case (state_ff)
         S_SCREEN: cmd.mod_start = !status.n_small && !status.n_even && !status.d_even;
         S_STRIP:  begin
            cmd.strip_d   = status.d_even;
            cmd.mod_start = !status.d_even;
         end
         S_EXP:    begin
            cmd.mul_sel_rb = status.e_odd;
            cmd.mul_start  = !status.e_zero;
         end
         S_MUL_R:  cmd.mul_sel_rb = 1'b1;
         S_BSQ:    cmd.mul_start = 1'b1;
         S_ADV:    cmd.shift_d = 1'b1;
         S_SQ:     begin
            cmd.mul_sel_sq = 1'b1;
            cmd.sq_y       = status.mul_done;
         end
         S_CHECK:  begin
            cmd.mul_sel_sq = 1'b1;
            cmd.mul_start  = !status.t_nm1 && !status.y_one && !status.y_nm1;
         end
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         pp_ff    <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (start) begin
               state_ff <= S_SCREEN;
               busy_ff  <= 1'b1;
            end
            S_SCREEN: begin
               if (status.n_small || status.n_even) begin
                  valid_ff <= 1'b1;
                  pp_ff    <= status.n_two;
                  busy_ff  <= 1'b0;
                  state_ff <= S_IDLE;
               end else if (status.d_even) state_ff <= S_STRIP;
               else state_ff <= S_MOD;
            end
            S_STRIP: if (!status.d_even) state_ff <= S_MOD;
            S_MOD: if (status.mod_done) state_ff <= S_EXP;
            S_EXP: begin
               if (status.e_zero) state_ff <= S_CHECK;
               else if (status.e_odd) state_ff <= S_MUL_R;
               else state_ff <= S_MUL_B;
            end
            S_MUL_R: if (status.mul_done) state_ff <= S_BSQ;
            S_BSQ:   state_ff <= S_MUL_B;
            S_MUL_B: if (status.mul_done) state_ff <= S_ADV;
            S_ADV:   state_ff <= S_EXP;
            S_CHECK: begin
               if (cmd.mul_start) state_ff <= S_SQ;
               else begin
                  valid_ff <= 1'b1;
                  pp_ff    <= status.y_nm1 || status.t_odd;
                  busy_ff  <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            S_SQ: if (status.mul_done) state_ff <= S_CHECK;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy               = busy_ff;
   assign rsp_valid          = valid_ff;
   assign rsp_probable_prime = pp_ff;
endmodule

// ===== hdl/miller_rabin_witness_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// miller_rabin_witness_test
// Strong probable prime test of a candidate to a witness base.
// Candidates below 2 or even are answered at screening; others take the
// base reduction and a series of bit-serial modular multiplies. One
// request at a time; busy high while working. Synchronous active-high
// reset returns to idle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module miller_rabin_witness_test
   import mrwt_pkg::*;
#(
   parameter int WIDTH = DEFAULT_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [WIDTH-1:0] req_candidate,
   input  logic [WIDTH-1:0] req_witness_base,
   output logic             rsp_valid,
   output logic             rsp_probable_prime
);
   cmd_type    cmd;
   status_type status;

   mrwt_control u_ctl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .rsp_valid(rsp_valid), .rsp_probable_prime(rsp_probable_prime),
      .status(status), .cmd(cmd)
   );

   mrwt_datapath #(.WIDTH(WIDTH)) u_dp (
      .clock(clock), .reset(reset), .candidate(req_candidate),
      .witness_base(req_witness_base), .cmd(cmd), .status(status)
   );
endmodule
